// File: src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg - shared types and constants
// Coefficient view, divider cell state and register indexes for the
// barometric sensor compensation core.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COEFFS  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_A      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_B      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_NINE   = 4'd3;

   localparam logic signed [33:0] T_OFFSET = 34'sd128000;
   localparam logic [20:0]        P_BASE   = 21'd1048576;
   localparam logic [63:0]        P_SCALE  = 64'd3125;
   localparam logic signed [31:0] TC_ROUND = 32'sd128;
   localparam logic [63:0]        X1_BIAS  = 64'h0000_8000_0000_0000;

   localparam int DIV_STEPS = 64;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic               neg_q;
      logic               invalid;
      logic signed [31:0] fine;
      logic signed [31:0] centi;
   } side_type;

   typedef struct packed {
      logic        valid;
      logic [30:0] rem;
      logic [63:0] nq;
      logic [30:0] divisor;
      side_type    side;
   } div_cell_type;

   typedef struct packed {
      logic signed [31:0] fine;
      logic signed [31:0] centi;
      logic [31:0]        pressure;
      logic               invalid;
   } result_type;

endpackage

// File: src/bsc_if.sv
// ----------------------------------------------------------------------------
// bsc_if - channel interfaces
// Sample, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] fine_temperature;
   logic signed [31:0] temperature_centi;
   logic [31:0]        pressure_pa;
   logic               pressure_invalid;
   modport source (output valid, fine_temperature, temperature_centi, pressure_pa,
                   pressure_invalid, input ready);
   modport sink   (input valid, fine_temperature, temperature_centi, pressure_pa,
                   pressure_invalid, output ready);
endinterface

interface bsc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front - temperature path and pressure operand pipeline
// Eleven stages from raw readings to signed dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
module bsc_front
   import bsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         load,
   input  logic         in_valid,
   input  logic [19:0]  raw_temperature,
   input  logic [19:0]  raw_pressure,
   input  coeff_type    cf,
   output logic         stage1_valid,
   output div_cell_type head
);

   logic [9:0] v_ff;

   logic signed [17:0] ta_ff, ta_in;
   logic signed [16:0] td_ff, td_in;
   logic [19:0]        adp1_ff, adp2_ff, adp3_ff, adp4_ff, adp5_ff, adp6_ff, adp7_ff;
   logic [19:0]        adp8_ff;

   logic signed [33:0] ma, msq;
   logic [31:0]        a2_ff, sq2_ff;

   logic signed [31:0] sqs;
   logic signed [47:0] mb;
   logic signed [31:0] v1_ff;
   logic [31:0]        b3_ff;

   logic signed [31:0] fine4_ff, fine5_ff, fine6_ff, fine7_ff, fine8_ff, fine9_ff;
   logic signed [31:0] fine10_ff;
   logic signed [31:0] tc5_ff, tc6_ff, tc7_ff, tc8_ff, tc9_ff, tc10_ff, tc_in;

   logic signed [33:0] x1_ff;
   logic signed [67:0] sqx;
   logic [63:0]        sqx_ff, m5_ff, m2_ff, m5b_ff, m2b_ff, x2a_ff, xb_ff;
   logic [63:0]        x2_ff, x1b_ff, x1c_ff, n1_ff, num_ff;
   logic signed [30:0] den_ff;
   logic [20:0]        pn;
   logic [63:0]        num_mag;
   logic [30:0]        den_mag;
   div_cell_type       head_ff;

   assign stage1_valid = v_ff[0];
   assign head         = head_ff;

   assign ta_in = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cf.t1, 1'b0});
   assign td_in = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cf.t1});
   assign ma    = ta_ff * cf.t2;
   assign msq   = td_ff * td_ff;
   assign sqs   = $signed(sq2_ff) >>> 12;
   assign mb    = sqs * cf.t3;
   assign tc_in = (fine4_ff * 32'sd5 + TC_ROUND) >>> 8;
   assign sqx   = x1_ff * x1_ff;
   assign pn    = P_BASE - {1'b0, adp8_ff};
   assign num_mag = num_ff[63] ? 64'd0 - num_ff : num_ff;
   assign den_mag = den_ff[30] ? 31'd0 - 31'(den_ff) : 31'(den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load) v_ff[0] <= in_valid;
         if (en) begin
            v_ff[9:1] <= v_ff[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (en) begin
         head_ff.valid <= v_ff[9];
      end
      if (load) begin
         ta_ff   <= ta_in;
         td_ff   <= td_in;
         adp1_ff <= raw_pressure;
      end
      if (en) begin
         a2_ff    <= ma[31:0];
         sq2_ff   <= msq[31:0];
         adp2_ff  <= adp1_ff;
         v1_ff    <= $signed(a2_ff) >>> 11;
         b3_ff    <= mb[31:0];
         adp3_ff  <= adp2_ff;
         fine4_ff <= v1_ff + ($signed(b3_ff) >>> 14);
         adp4_ff  <= adp3_ff;
         fine5_ff <= fine4_ff;
         tc5_ff   <= tc_in;
         x1_ff    <= 34'(fine4_ff) - T_OFFSET;
         adp5_ff  <= adp4_ff;
         sqx_ff   <= sqx[63:0];
         m5_ff    <= 64'(x1_ff * cf.p5);
         m2_ff    <= 64'(x1_ff * cf.p2);
         fine6_ff <= fine5_ff;
         tc6_ff   <= tc5_ff;
         adp6_ff  <= adp5_ff;
         x2a_ff   <= 64'($signed(sqx_ff) * 64'(cf.p6));
         xb_ff    <= 64'($signed(sqx_ff) * 64'(cf.p3));
         m5b_ff   <= m5_ff;
         m2b_ff   <= m2_ff;
         fine7_ff <= fine6_ff;
         tc7_ff   <= tc6_ff;
         adp7_ff  <= adp6_ff;
         x2_ff    <= x2a_ff + (m5b_ff << 17) + (64'(cf.p4) << 35);
         x1b_ff   <= 64'($signed(xb_ff) >>> 8) + (m2b_ff << 12);
         fine8_ff <= fine7_ff;
         tc8_ff   <= tc7_ff;
         adp8_ff  <= adp7_ff;
         x1c_ff   <= 64'((X1_BIAS + x1b_ff) * 64'(cf.p1));
         n1_ff    <= (64'(pn) << 31) - x2_ff;
         fine9_ff <= fine8_ff;
         tc9_ff   <= tc8_ff;
         num_ff   <= 64'(n1_ff * P_SCALE);
         den_ff   <= $signed(x1c_ff[63:33]);
         fine10_ff <= fine9_ff;
         tc10_ff   <= tc9_ff;
         head_ff.side.fine    <= fine10_ff;
         head_ff.side.centi   <= tc10_ff;
         head_ff.side.invalid <= (den_ff == '0);
         head_ff.side.neg_q   <= num_ff[63] ^ den_ff[30];
         head_ff.rem          <= '0;
         head_ff.nq           <= num_mag;
         head_ff.divisor      <= (den_ff == '0) ? 31'd1 : den_mag;
      end
   end

endmodule

// File: src/bsc_div_cell.sv
// ----------------------------------------------------------------------------
// bsc_div_cell - one restoring division step
// Shift one dividend bit into the remainder, subtract when it fits, pass on.
// ----------------------------------------------------------------------------
module bsc_div_cell
   import bsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  div_cell_type d,
   output div_cell_type q
);

   logic [31:0]  trial, diff;
   logic         fits;
   div_cell_type q_ff, q_in;

   assign trial = {d.rem, d.nq[63]};
   assign diff  = trial - {1'b0, d.divisor};
   assign fits  = trial >= {1'b0, d.divisor};

   always_comb begin
      q_in     = d;
      q_in.rem = fits ? diff[30:0] : trial[30:0];
      q_in.nq  = {d.nq[62:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: src/bsc_divider.sv
// ----------------------------------------------------------------------------
// bsc_divider - row of division cells
// One quotient bit per cell; the quotient leaves in place of the dividend.
// ----------------------------------------------------------------------------
module bsc_divider
   import bsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  div_cell_type head,
   output div_cell_type tail
);

   div_cell_type link [0:DIV_STEPS];

   assign link[0] = head;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      bsc_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (link[i]),
         .q     (link[i+1])
      );
   end

   assign tail = link[DIV_STEPS];

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> tail.rem < tail.divisor)
      else $error("division remainder not below divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> head.divisor != '0)
      else $error("zero divisor entered division row");

endmodule

// File: src/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back - pressure correction and result register
// Sign the quotient, apply the square and linear terms, hold the result beat.
// ----------------------------------------------------------------------------
module bsc_back
   import bsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  div_cell_type tail,
   input  coeff_type    cf,
   output logic         out_valid,
   output result_type   result
);

   logic [3:0]  v_ff;
   logic        out_valid_ff;
   side_type    s1_ff, s2_ff, s3_ff, s4_ff;
   logic [63:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [63:0] q13;
   logic [31:0] ql;
   logic signed [18:0] qh;
   logic signed [51:0] hl;
   logic [63:0] ll_ff, y2m_ff, qsq_ff, y2_ff, y2b_ff, y1m_ff;
   logic [30:0] hl_ff;
   logic [63:0] sum, res;
   result_type  result_ff;

   assign q13 = $signed(p1_ff) >>> 13;
   assign ql  = q13[31:0];
   assign qh  = q13[50:32];
   assign hl  = qh * $signed({1'b0, ql});
   assign sum = p4_ff + 64'($signed(y1m_ff) >>> 25) + y2b_ff;
   assign res = 64'($signed(sum) >>> 8) + (64'(cf.p7) << 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[2:0], tail.valid};
         out_valid_ff <= v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= tail.side.neg_q ? 64'd0 - tail.nq : tail.nq;
         s1_ff  <= tail.side;
         ll_ff  <= 64'(ql) * 64'(ql);
         hl_ff  <= hl[30:0];
         y2m_ff <= 64'($signed(p1_ff) * 64'(cf.p8));
         p2_ff  <= p1_ff;
         s2_ff  <= s1_ff;
         qsq_ff <= ll_ff + {hl_ff, 33'd0};
         y2_ff  <= 64'($signed(y2m_ff) >>> 19);
         p3_ff  <= p2_ff;
         s3_ff  <= s2_ff;
         y1m_ff <= 64'($signed(qsq_ff) * 64'(cf.p9));
         y2b_ff <= y2_ff;
         p4_ff  <= p3_ff;
         s4_ff  <= s3_ff;
         result_ff.fine     <= s4_ff.fine;
         result_ff.centi    <= s4_ff.centi;
         result_ff.invalid  <= s4_ff.invalid;
         result_ff.pressure <= s4_ff.invalid ? 32'd0 : res[31:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

endmodule

// File: src/baro_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core - barometric sensor compensation
// Fine temperature, centidegrees and pressure from raw readings.
//
//   channel   dir  payload                                       beat
//   req_bus   in   raw_temperature, raw_pressure                 valid & ready
//   rsp_bus   out  fine_temperature, temperature_centi,          valid & ready
//                  pressure_pa, pressure_invalid
//   csr_bus   in   index, data                                   valid & ready
//
// One sample pair per cycle unless the result beat stalls. From request beat
// to result beat: 11 operand stages, 64 division cells, 5 correction stages.
// Synchronous reset clears coefficients and all valid bits.
// A stalled result beat holds the whole pipeline; the first stage still
// takes a request beat when empty.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core
   import bsc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bsc_req_if.sink   req_bus,
   bsc_rsp_if.source rsp_bus,
   bsc_csr_if.sink   csr_bus
);

   logic [47:0]  temp_ff;
   logic [63:0]  pa_ff, pb_ff;
   logic [15:0]  p9_ff;
   coeff_type    cf;
   logic         en, load, stage1_valid, out_valid;
   div_cell_type head, tail;
   result_type   result;
   logic signed [31:0] centi_chk;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         pa_ff   <= '0;
         pb_ff   <= '0;
         p9_ff   <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_TEMP_COEFFS: temp_ff <= csr_bus.data[47:0];
            CSR_PRESS_A:     pa_ff   <= csr_bus.data;
            CSR_PRESS_B:     pb_ff   <= csr_bus.data;
            CSR_PRESS_NINE:  p9_ff   <= csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   assign cf.t1 = temp_ff[15:0];
   assign cf.t2 = $signed(temp_ff[31:16]);
   assign cf.t3 = $signed(temp_ff[47:32]);
   assign cf.p1 = pa_ff[15:0];
   assign cf.p2 = $signed(pa_ff[31:16]);
   assign cf.p3 = $signed(pa_ff[47:32]);
   assign cf.p4 = $signed(pa_ff[63:48]);
   assign cf.p5 = $signed(pb_ff[15:0]);
   assign cf.p6 = $signed(pb_ff[31:16]);
   assign cf.p7 = $signed(pb_ff[47:32]);
   assign cf.p8 = $signed(pb_ff[63:48]);
   assign cf.p9 = $signed(p9_ff);

   assign en            = ~out_valid | rsp_bus.ready;
   assign load          = en | ~stage1_valid;
   assign req_bus.ready = load;

   bsc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .load            (load),
      .in_valid        (req_bus.valid),
      .raw_temperature (req_bus.raw_temperature),
      .raw_pressure    (req_bus.raw_pressure),
      .cf              (cf),
      .stage1_valid    (stage1_valid),
      .head            (head)
   );

   bsc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .head  (head),
      .tail  (tail)
   );

   bsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .tail      (tail),
      .cf        (cf),
      .out_valid (out_valid),
      .result    (result)
   );

   assign rsp_bus.valid             = out_valid;
   assign rsp_bus.fine_temperature  = result.fine;
   assign rsp_bus.temperature_centi = result.centi;
   assign rsp_bus.pressure_pa       = result.pressure;
   assign rsp_bus.pressure_invalid  = result.invalid;

   assign centi_chk = (result.fine * 32'sd5 + TC_ROUND) >>> 8;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.pressure_invalid |-> rsp_bus.pressure_pa == '0)
      else $error("invalid pressure beat with nonzero value");

   a_centi_match: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.temperature_centi == centi_chk)
      else $error("centidegrees out of step with fine temperature");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - barometric sensor compensation core
// Feeds raw temperature/pressure pairs under several coefficient sets, with
// random idling on both channels; checks each result beat against a typed
// row's result or an in-bench integer model of the compensation arithmetic.
// ----------------------------------------------------------------------------
module testbench;
   import bsc_pkg::*;

   typedef struct {
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      bit          typed;
      result_type  res;
   } sample_type;

   logic clock;
   logic reset;

   bsc_req_if req_bus();
   bsc_rsp_if rsp_bus();
   bsc_csr_if csr_bus();

   baro_sensor_compensation_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [47:0] temp_coeffs;
   logic [63:0] press_a;
   logic [63:0] press_b;
   logic [15:0] press_nine;

   sample_type offered_q[$];
   result_type awaited_q[$];
   int         fail_count = 0;
   bit         idling = 1'b1;
   bit         long_hold = 1'b0;

   localparam result_type UNCALIBRATED = '{fine: 0, centi: 0, pressure: 0, invalid: 1'b1};

   sample_type directed_rows[] = '{
      '{20'h00000, 20'h00000, 1'b1, UNCALIBRATED},
      '{20'hFFFFF, 20'hFFFFF, 1'b1, UNCALIBRATED},
      '{20'h00000, 20'hFFFFF, 1'b1, UNCALIBRATED},
      '{20'hFFFFF, 20'h00000, 1'b1, UNCALIBRATED},
      '{20'h55555, 20'hAAAAA, 1'b1, UNCALIBRATED},
      '{20'd519888, 20'd415148, 1'b0, UNCALIBRATED},
      '{20'h00000, 20'h00000, 1'b0, UNCALIBRATED},
      '{20'hFFFFF, 20'hFFFFF, 1'b0, UNCALIBRATED},
      '{20'h00000, 20'hFFFFF, 1'b0, UNCALIBRATED},
      '{20'hFFFFF, 20'h00000, 1'b0, UNCALIBRATED},
      '{20'h80000, 20'h80000, 1'b0, UNCALIBRATED},
      '{20'h7FFFF, 20'h00001, 1'b0, UNCALIBRATED},
      '{20'h55555, 20'hAAAAA, 1'b0, UNCALIBRATED},
      '{20'hAAAAA, 20'h55555, 1'b0, UNCALIBRATED},
      '{20'd400000, 20'd300000, 1'b0, UNCALIBRATED},
      '{20'd600000, 20'd500000, 1'b0, UNCALIBRATED}
   };

   function automatic result_type compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      logic signed [31:0] adt, st1, st2, st3, a, d, b, fine;
      logic signed [63:0] sp1, sp2, sp3, sp4, sp5, sp6, sp7, sp8, sp9;
      logic signed [63:0] x1, x2, n, p, q, y1, y2;
      result_type r;
      adt = {12'b0, raw_t};
      st1 = {16'b0, temp_coeffs[15:0]};
      st2 = $signed(temp_coeffs[31:16]);
      st3 = $signed(temp_coeffs[47:32]);
      sp1 = {48'b0, press_a[15:0]};
      sp2 = $signed(press_a[31:16]);
      sp3 = $signed(press_a[47:32]);
      sp4 = $signed(press_a[63:48]);
      sp5 = $signed(press_b[15:0]);
      sp6 = $signed(press_b[31:16]);
      sp7 = $signed(press_b[47:32]);
      sp8 = $signed(press_b[63:48]);
      sp9 = $signed(press_nine);
      a = ((adt >>> 3) - (st1 <<< 1)) * st2;
      d = (adt >>> 4) - st1;
      b = ((d * d) >>> 12) * st3;
      fine = (a >>> 11) + (b >>> 14);
      r.fine = fine;
      r.centi = (fine * 32'sd5 + TC_ROUND) >>> 8;
      x1 = 64'(fine) - 64'sd128000;
      x2 = x1 * x1 * sp6 + ((x1 * sp5) <<< 17) + (sp4 <<< 35);
      x1 = ((x1 * x1 * sp3) >>> 8) + ((x1 * sp2) <<< 12);
      x1 = (((64'sd1 <<< 47) + x1) * sp1) >>> 33;
      r.pressure = '0;
      r.invalid = (x1 == 0);
      if (x1 != 0) begin
         p = 64'sd1048576 - $signed({44'b0, raw_p});
         n = ((p <<< 31) - x2) * 64'sd3125;
         if (n == {1'b1, 63'b0} && x1 == -64'sd1)
            p = n;
         else
            p = n / x1;
         q = p >>> 13;
         y1 = (sp9 * q * q) >>> 25;
         y2 = (sp8 * p) >>> 19;
         p = ((p + y1 + y2) >>> 8) + (sp7 <<< 4);
         r.pressure = p[31:0];
      end
      return r;
   endfunction

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      sample_type s;
      result_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_TEMP_COEFFS: temp_coeffs = csr_bus.data[47:0];
               CSR_PRESS_A:     press_a = csr_bus.data;
               CSR_PRESS_B:     press_b = csr_bus.data;
               CSR_PRESS_NINE:  press_nine = csr_bus.data[15:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            s = offered_q.pop_front();
            awaited_q.push_back(s.typed ? s.res
                                        : compensate(req_bus.raw_temperature,
                                                     req_bus.raw_pressure));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_q.size() == 0) begin
               $error("result beat with nothing awaited");
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_bus.fine_temperature !== want.fine) begin
                  $error("fine_temperature: expected %0d, got %0d", want.fine,
                         rsp_bus.fine_temperature);
                  fail_count++;
               end
               if (rsp_bus.temperature_centi !== want.centi) begin
                  $error("temperature_centi: expected %0d, got %0d", want.centi,
                         rsp_bus.temperature_centi);
                  fail_count++;
               end
               if (rsp_bus.pressure_pa !== want.pressure) begin
                  $error("pressure_pa: expected %h, got %h", want.pressure,
                         rsp_bus.pressure_pa);
                  fail_count++;
               end
               if (rsp_bus.pressure_invalid !== want.invalid) begin
                  $error("pressure_invalid: expected %b, got %b", want.invalid,
                         rsp_bus.pressure_invalid);
                  fail_count++;
               end
            end
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(sample_type s);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      offered_q.push_back(s);
      req_bus.valid <= 1'b1;
      req_bus.raw_temperature <= s.raw_t;
      req_bus.raw_pressure <= s.raw_p;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [63:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (offered_q.size() != 0 || awaited_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic load_coeffs(int set);
      case (set)
         0: begin
            write_reg(CSR_TEMP_COEFFS, {16'h0000, 16'hFC18, 16'd26435, 16'd27504});
            write_reg(CSR_PRESS_A, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
            write_reg(CSR_PRESS_B, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
            write_reg(CSR_PRESS_NINE, 64'd6000);
         end
         1: begin
            write_reg(CSR_TEMP_COEFFS, {16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF});
            write_reg(CSR_PRESS_A, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF});
            write_reg(CSR_PRESS_B, {4{16'h7FFF}});
            write_reg(CSR_PRESS_NINE, 64'h7FFF);
         end
         2: begin
            write_reg(CSR_TEMP_COEFFS, {16'h0000, 16'h8000, 16'h8000, 16'h0000});
            write_reg(CSR_PRESS_A, {16'h8000, 16'h8000, 16'h8000, 16'h0001});
            write_reg(CSR_PRESS_B, {4{16'h8000}});
            write_reg(CSR_PRESS_NINE, 64'hFFFF_FFFF_FFFF_8000);
         end
         3: begin
            write_reg(CSR_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(CSR_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(CSR_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(CSR_PRESS_NINE, 64'hFFFF_FFFF_FFFF_FFFF);
         end
         4: begin
            write_reg(CSR_PRESS_A, rand64() << 16);
         end
         default: begin
            write_reg(CSR_TEMP_COEFFS, rand64());
            write_reg(CSR_PRESS_A, rand64());
            write_reg(CSR_PRESS_B, rand64());
            write_reg(CSR_PRESS_NINE, rand64());
         end
      endcase
      write_reg(CSR_PRESS_NINE + 4'($urandom_range(1, 12)), rand64());
      csr_bus.valid <= 1'b0;
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      s.typed = 1'b0;
      if ($urandom_range(0, 1)) begin
         s.raw_t = 20'($urandom_range(0, 20'hFFFFF));
         s.raw_p = 20'($urandom_range(0, 20'hFFFFF));
      end else begin
         s.raw_t = 20'($urandom_range(400000, 640000));
         s.raw_p = 20'($urandom_range(200000, 600000));
      end
      return s;
   endfunction

   initial begin
      temp_coeffs = '0;
      press_a = '0;
      press_b = '0;
      press_nine = '0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.raw_temperature <= '0;
      req_bus.raw_pressure <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         if (directed_rows[i].typed) send_sample(directed_rows[i]);
      drain();
      load_coeffs(0);
      foreach (directed_rows[i])
         if (!directed_rows[i].typed) send_sample(directed_rows[i]);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) load_coeffs(phase == 6 ? 0 : phase);
         if (phase == 2) long_hold = 1'b1;
         if (phase == 6) idling = 1'b0;
         for (int k = 0; k < 75; k++) begin
            send_sample(random_sample());
            if (phase == 1 && k == 40) drain();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
src/bsc_pkg.sv
src/bsc_if.sv
src/bsc_front.sv
src/bsc_div_cell.sv
src/bsc_divider.sv
src/bsc_back.sv
src/baro_sensor_compensation_core.sv
bench/testbench.sv
